>>> rtl/led_pixel_buffer_hsv_macros.svh
// Assertion helpers for the LED pixel buffer
`ifndef LED_PIXEL_BUFFER_HSV_MACROS_SVH
`define LED_PIXEL_BUFFER_HSV_MACROS_SVH

// Clocked property, switched off while reset is held
`define LPB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that holds in and out of reset
`define LPB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/lpb_pkg.sv
package lpb_pkg;

    // Defaults for the top-level parameter and the register
    localparam int DEF_MAX_LEDS    = 256;
    localparam int LED_COUNT_RESET = 256;
    localparam int LED_COUNT_W     = 9;

    // Colour arithmetic
    localparam int COMP_W          = 8;
    localparam int COMP_MAX        = 255;
    localparam int HSV_REGION_SPAN = 43;
    localparam int HSV_REM_SCALE   = 6;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;    // take the input item
        logic calc;       // register the result colour, restart fill counter
        logic wr_single;  // write result to the addressed entry
        logic fill_step;  // write result at fill counter and advance
        logic out_load;   // move result into the output register
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic is_fill;    // item is a fill
        logic fill_zero;  // fill covers no entries
        logic fill_last;  // fill counter sits on the last entry
        logic out_free;   // output register can take a result
    } t_dp_sts;

endpackage

>>> rtl/led_pixel_buffer_hsv.sv
// Single-entry items (write, add, read) pass through the three-stage HSV
// multiplier pipeline. A new item is accepted only once the last result
// sits in the output register. Fill items write N = min(led_count, MAX_LEDS)
// entries; the single store write port takes one entry a cycle.
// Reset (synchronous, active low) clears control, the output register, the
// per-entry valid bits (store reads black) and sets led_count to 256.
module led_pixel_buffer_hsv #(
    parameter int MAX_LEDS = lpb_pkg::DEF_MAX_LEDS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // stream in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,  // led_index, in_red, in_green, in_blue, hue,
                                       // saturation, brightness (8 bits each)
    input  logic [2:0]  s_axis_tuser,  // func
    // stream out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // out_red, out_green, out_blue (8 bits each)
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int LCW = lpb_pkg::LED_COUNT_W;

    lpb_pkg::t_dp_cmd cmd;
    lpb_pkg::t_dp_sts sts;

    // led_count register
    logic [LCW-1:0] r_led_count;
    logic           reg_sel;

    assign reg_sel = (paddr[2] == 1'b0);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_count <= LCW'(lpb_pkg::LED_COUNT_RESET);
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_led_count <= pwdata[LCW-1:0];
        end
    end

    assign prdata = reg_sel ? {{(32 - LCW){1'b0}}, r_led_count} : 32'd0;

    lpb_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .i_sts         (sts),
        .o_cmd         (cmd)
    );

    lpb_datapath #(
        .MAX_LEDS (MAX_LEDS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_tdata     (s_axis_tdata),
        .i_tuser     (s_axis_tuser),
        .i_led_count (r_led_count),
        .i_m_tready  (m_axis_tready),
        .o_m_tvalid  (m_axis_tvalid),
        .o_m_tdata   (m_axis_tdata)
    );

endmodule

>>> rtl/lpb_ctrl.sv
module lpb_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  lpb_pkg::t_dp_sts i_sts,
    output lpb_pkg::t_dp_cmd o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_HSV1  = 3'd1;
    localparam logic [2:0] S_HSV2  = 3'd2;
    localparam logic [2:0] S_HSV3  = 3'd3;
    localparam logic [2:0] S_CALC  = 3'd4;
    localparam logic [2:0] S_WRITE = 3'd5;
    localparam logic [2:0] S_FILL  = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign s_axis_tready = (r_state == S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_HSV1;
                end
            end
            S_HSV1: n_state = S_HSV2;
            S_HSV2: n_state = S_HSV3;
            S_HSV3: n_state = S_CALC;
            S_CALC: begin
                o_cmd.calc = 1'b1;
                priority if (!i_sts.is_fill) begin
                    n_state = S_WRITE;
                end else if (i_sts.fill_zero) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_FILL;
                end
            end
            S_WRITE: begin
                o_cmd.wr_single = 1'b1;
                n_state         = S_DONE;
            end
            S_FILL: begin
                o_cmd.fill_step = 1'b1;
                if (i_sts.fill_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> rtl/lpb_datapath.sv
module lpb_datapath #(
    parameter int MAX_LEDS = lpb_pkg::DEF_MAX_LEDS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lpb_pkg::t_dp_cmd                  i_cmd,
    output lpb_pkg::t_dp_sts                  o_sts,
    input  logic [55:0]                       i_tdata,
    input  logic [2:0]                        i_tuser,
    input  logic [lpb_pkg::LED_COUNT_W-1:0]   i_led_count,
    input  logic                              i_m_tready,
    output logic                              o_m_tvalid,
    output logic [23:0]                       o_m_tdata
);

    localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam int CW = $clog2(MAX_LEDS + 1);
    localparam logic [lpb_pkg::LED_COUNT_W-1:0] MAX_CNT = lpb_pkg::LED_COUNT_W'(MAX_LEDS);
    localparam logic [7:0] CMAX = 8'(lpb_pkg::COMP_MAX);
    localparam logic [7:0] SPAN = 8'(lpb_pkg::HSV_REGION_SPAN);
    localparam logic [7:0] RSCL = 8'(lpb_pkg::HSV_REM_SCALE);

    localparam logic [2:0] FN_WR_RGB   = 3'd0;
    localparam logic [2:0] FN_ADD_RGB  = 3'd1;
    localparam logic [2:0] FN_WR_HSV   = 3'd2;
    localparam logic [2:0] FN_ADD_HSV  = 3'd3;
    localparam logic [2:0] FN_READ     = 3'd4;
    localparam logic [2:0] FN_FILL_RGB = 3'd5;
    localparam logic [2:0] FN_FILL_HSV = 3'd6;

    // hue / 43 by threshold compares
    function automatic logic [2:0] hue_region(input logic [7:0] h);
        logic [2:0] reg_n;
        reg_n = 3'd0;
        for (int k = 1; k < 6; k++) begin
            if (h >= 8'(k * lpb_pkg::HSV_REGION_SPAN)) begin
                reg_n = 3'(k);
            end
        end
        return reg_n;
    endfunction

    // Per-component add clipped at full scale
    function automatic logic [23:0] sat_add(input logic [23:0] a, input logic [23:0] b);
        logic [23:0] res;
        logic [8:0]  sum;
        res = '0;
        for (int k = 0; k < 3; k++) begin
            sum = {1'b0, a[k*8 +: 8]} + {1'b0, b[k*8 +: 8]};
            res[k*8 +: 8] = sum[8] ? CMAX : sum[7:0];
        end
        return res;
    endfunction

    // Captured item
    logic [2:0]  r_func;
    logic [7:0]  r_idx;
    logic [23:0] r_rgb;
    logic [7:0]  r_h;
    logic [7:0]  r_s;
    logic [7:0]  r_v;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func <= i_tuser;
            r_idx  <= i_tdata[7:0];
            r_rgb  <= {i_tdata[15:8], i_tdata[23:16], i_tdata[31:24]};
            r_h    <= i_tdata[39:32];
            r_s    <= i_tdata[47:40];
            r_v    <= i_tdata[55:48];
        end
    end

    logic          in_range;
    logic [AW-1:0] rd_addr;
    assign in_range = ({1'b0, r_idx} < MAX_CNT);
    assign rd_addr  = r_idx[AW-1:0];

    // HSV stage 1: region and scaled remainder
    logic [2:0] s1_region;
    logic [7:0] s1_off;
    logic [2:0] r1_region;
    logic [7:0] r1_rem;
    logic [7:0] r1_s;
    logic [7:0] r1_v;
    logic       r1_grey;

    assign s1_region = hue_region(r_h);
    assign s1_off    = r_h - (8'(s1_region) * SPAN);

    always_ff @(posedge i_clk) begin
        r1_region <= s1_region;
        r1_rem    <= s1_off * RSCL;
        r1_s      <= r_s;
        r1_v      <= r_v;
        r1_grey   <= (r_s == 8'd0);
    end

    // HSV stage 2: saturation products and p
    logic [15:0] s2_a_prod;
    logic [15:0] s2_b_prod;
    logic [15:0] s2_p_prod;
    logic [2:0]  r2_region;
    logic [7:0]  r2_a;
    logic [7:0]  r2_b;
    logic [7:0]  r2_p;
    logic [7:0]  r2_v;
    logic        r2_grey;

    assign s2_a_prod = {8'd0, r1_s} * {8'd0, r1_rem};
    assign s2_b_prod = {8'd0, r1_s} * {8'd0, CMAX - r1_rem};
    assign s2_p_prod = {8'd0, r1_v} * {8'd0, CMAX - r1_s};

    always_ff @(posedge i_clk) begin
        r2_region <= r1_region;
        r2_a      <= s2_a_prod[15:8];
        r2_b      <= s2_b_prod[15:8];
        r2_p      <= s2_p_prod[15:8];
        r2_v      <= r1_v;
        r2_grey   <= r1_grey;
    end

    // HSV stage 3: q and t
    logic [15:0] s3_q_prod;
    logic [15:0] s3_t_prod;
    logic [2:0]  r3_region;
    logic [7:0]  r3_p;
    logic [7:0]  r3_q;
    logic [7:0]  r3_t;
    logic [7:0]  r3_v;
    logic        r3_grey;

    assign s3_q_prod = {8'd0, r2_v} * {8'd0, CMAX - r2_a};
    assign s3_t_prod = {8'd0, r2_v} * {8'd0, CMAX - r2_b};

    always_ff @(posedge i_clk) begin
        r3_region <= r2_region;
        r3_p      <= r2_p;
        r3_q      <= s3_q_prod[15:8];
        r3_t      <= s3_t_prod[15:8];
        r3_v      <= r2_v;
        r3_grey   <= r2_grey;
    end

    // Region select, colour packed red high
    logic [23:0] hsv_rgb;
    always_comb begin
        if (r3_grey) begin
            hsv_rgb = {r3_v, r3_v, r3_v};
        end else begin
            unique case (r3_region)
                3'd0:    hsv_rgb = {r3_v, r3_t, r3_p};
                3'd1:    hsv_rgb = {r3_q, r3_v, r3_p};
                3'd2:    hsv_rgb = {r3_p, r3_v, r3_t};
                3'd3:    hsv_rgb = {r3_p, r3_q, r3_v};
                3'd4:    hsv_rgb = {r3_t, r3_p, r3_v};
                default: hsv_rgb = {r3_v, r3_p, r3_q};
            endcase
        end
    end

    // Pixel store; entries not yet written read as black
    logic [23:0]         r_mem [MAX_LEDS];
    logic [MAX_LEDS-1:0] r_valid;
    logic [23:0]         r_rd_data;
    logic                r_rd_valid;
    logic [23:0]         cur;

    always_ff @(posedge i_clk) begin
        r_rd_data  <= r_mem[rd_addr];
        r_rd_valid <= r_valid[rd_addr];
    end

    assign cur = r_rd_valid ? r_rd_data : 24'd0;

    // Result colour
    logic        is_fill;
    logic [23:0] n_res;
    logic [23:0] r_res;

    assign is_fill = (r_func == FN_FILL_RGB) || (r_func == FN_FILL_HSV);

    always_comb begin
        unique case (r_func)
            FN_WR_RGB:   n_res = r_rgb;
            FN_ADD_RGB:  n_res = sat_add(cur, r_rgb);
            FN_WR_HSV:   n_res = hsv_rgb;
            FN_ADD_HSV:  n_res = sat_add(cur, hsv_rgb);
            FN_READ:     n_res = cur;
            FN_FILL_RGB: n_res = r_rgb;
            FN_FILL_HSV: n_res = hsv_rgb;
            default:     n_res = cur;
        endcase
        if (!is_fill && !in_range) begin
            n_res = 24'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_res <= n_res;
        end
    end

    // Fill counter
    logic [lpb_pkg::LED_COUNT_W-1:0] fill_n_full;
    logic [CW-1:0]                   fill_n;
    logic [CW-1:0]                   r_fill_idx;

    assign fill_n_full = (i_led_count > MAX_CNT) ? MAX_CNT : i_led_count;
    assign fill_n      = fill_n_full[CW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_fill_idx <= '0;
        end else if (i_cmd.fill_step) begin
            r_fill_idx <= r_fill_idx + 1'b1;
        end
    end

    // Single write port
    logic          wr_en;
    logic [AW-1:0] wr_addr;

    assign wr_en   = (i_cmd.wr_single && in_range) || i_cmd.fill_step;
    assign wr_addr = i_cmd.fill_step ? r_fill_idx[AW-1:0] : rd_addr;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (wr_en) begin
            r_valid[wr_addr] <= 1'b1;
        end
    end

    // Output register
    logic        r_out_valid;
    logic [23:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= {r_res[7:0], r_res[15:8], r_res[23:16]};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // Status
    assign o_sts.is_fill   = is_fill;
    assign o_sts.fill_zero = (fill_n == '0);
    assign o_sts.fill_last = (CW'(r_fill_idx + 1'b1) == fill_n);
    assign o_sts.out_free  = !r_out_valid || i_m_tready;

endmodule

>>> rtl/lpb_checker.sv
`include "led_pixel_buffer_hsv_macros.svh"

module lpb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [55:0] s_axis_tdata,
    input logic [2:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);

    // register port never stalls
    `LPB_ASSERT_ALWAYS(a_pready_high, i_clk, pready == 1'b1, "pready dropped")

    // one item at a time: no accept straight after an accept
    `LPB_ASSERT(a_no_b2b, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && i_rst_n |=> !s_axis_tready, "item accepted while busy")

    // pending result is held until taken
    `LPB_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready && i_rst_n |=> m_axis_tvalid, "result dropped")

    // led_count reads back what was written
    `LPB_ASSERT(a_cfg_rdback, i_clk, i_rst_n, psel && penable && pwrite && !paddr[2] && i_rst_n |=> prdata[8:0] == $past(pwdata[8:0]), "led_count readback mismatch")

endmodule

bind led_pixel_buffer_hsv lpb_checker u_lpb_checker (.*);
